>>> src/slec_pkg.sv
// ----------------------------------------------------------------------------
// Sequential list engine package
// Shared sizes, command and status codes, and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package slec_pkg;

  // List capacity and stored word width.
  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;

  // Derived widths: entry index, and a count that can hold DEPTH itself.
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths of the stream items.
  localparam int CMD_FW  = 3;
  localparam int POS_FW  = 5;
  localparam int VAL_FW  = 32;
  localparam int STAT_FW = 2;
  localparam int CNT_FW  = 5;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 40;

  // Width used to compare a position against the count without loss.
  localparam int PW = (CNT_W > POS_FW) ? CNT_W : POS_FW;

  // Command codes.
  localparam logic [CMD_FW-1:0] CMD_INSERT_AT  = 3'd0;
  localparam logic [CMD_FW-1:0] CMD_ERASE_AT   = 3'd1;
  localparam logic [CMD_FW-1:0] CMD_PUSH_FRONT = 3'd2;
  localparam logic [CMD_FW-1:0] CMD_PUSH_BACK  = 3'd3;
  localparam logic [CMD_FW-1:0] CMD_POP_FRONT  = 3'd4;
  localparam logic [CMD_FW-1:0] CMD_POP_BACK   = 3'd5;
  localparam logic [CMD_FW-1:0] CMD_FIND       = 3'd6;
  localparam logic [CMD_FW-1:0] CMD_CLEAR      = 3'd7;

  // Status codes.
  localparam logic [STAT_FW-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_FW-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_FW-1:0] ST_BAD  = 2'd2;

  // Which walk a decoded command needs.
  localparam logic [1:0] RT_DONE   = 2'd0;
  localparam logic [1:0] RT_UP     = 2'd1;
  localparam logic [1:0] RT_DOWN   = 2'd2;
  localparam logic [1:0] RT_SEARCH = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic exec;
    logic shift_up;
    logic shift_down;
    logic search;
    logic out_load;
  } dp_ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] route;
    logic       step_done;
    logic       out_free;
  } dp_sts_t;

endpackage

>>> src/slec_ctrl.sv
// ----------------------------------------------------------------------------
// Sequential list engine controller
// State machine that takes one command, sequences the datapath through
// the needed walk over the list, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module slec_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  slec_pkg::dp_sts_t sts,
  output slec_pkg::dp_ctl_t ctl
);
  import slec_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_UP     = 3'd2;
  localparam logic [2:0] S_DOWN   = 3'd3;
  localparam logic [2:0] S_SEARCH = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands. No transfer is taken during reset.
  always_comb begin
    ctl        = '0;
    state_next = state;
    s_tready   = (state == S_IDLE) && !rst;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && !rst) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        unique case (sts.route)
          RT_UP:     state_next = S_UP;
          RT_DOWN:   state_next = S_DOWN;
          RT_SEARCH: state_next = S_SEARCH;
          default:   state_next = S_DONE;
        endcase
      end
      S_UP: begin
        ctl.shift_up = 1'b1;
        if (sts.step_done) state_next = S_DONE;
      end
      S_DOWN: begin
        ctl.shift_down = 1'b1;
        if (sts.step_done) state_next = S_DONE;
      end
      S_SEARCH: begin
        ctl.search = 1'b1;
        if (sts.step_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/slec_dpath.sv
// ----------------------------------------------------------------------------
// Sequential list engine datapath
// Holds the list memory, the entry count, the walk index and the output
// register. Shifts and searches move one entry per cycle through a
// registered-read memory.
// ----------------------------------------------------------------------------
module slec_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  slec_pkg::dp_ctl_t                    ctl,
  output slec_pkg::dp_sts_t                    sts,
  input  logic [slec_pkg::CMD_FW-1:0]          command,
  input  logic [slec_pkg::POS_FW-1:0]          position,
  input  logic signed [slec_pkg::VAL_FW-1:0]   value,
  input  logic                                 m_tready,
  output logic                                 m_tvalid,
  output logic [slec_pkg::STAT_FW-1:0]         status,
  output logic signed [slec_pkg::VAL_FW-1:0]   find_result,
  output logic [slec_pkg::CNT_FW-1:0]          entry_count
);
  import slec_pkg::*;

  // List storage.
  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rdata;

  // Captured command.
  logic [CMD_FW-1:0]        cmd_q;
  logic [POS_FW-1:0]        pos_q;
  logic signed [VAL_FW-1:0] val_q;

  // Walk state.
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   tpos;
  logic               pend;
  logic [IDX_W-1:0]   waddr_q;
  logic               found;
  logic [STAT_FW-1:0] status_q;

  // Decode results.
  logic [STAT_FW-1:0] exec_status;
  logic [1:0]         exec_route;
  logic [CNT_W-1:0]   exec_tpos;
  logic [CNT_W-1:0]   exec_k;
  logic [PW-1:0]      pos_ext;
  logic [PW-1:0]      cnt_ext;
  logic               full;
  logic               empty;
  logic [CNT_W-1:0]   pos_cnt;
  logic [CNT_W-1:0]   cnt_m1;

  // Walk controls.
  logic [CNT_W-1:0]      km1;
  logic [CNT_W-1:0]      kp1;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [WORD_WIDTH-1:0] wdata;
  logic [IDX_W-1:0]      raddr;
  logic                  rd_issue;
  logic                  step_done;
  logic                  match;
  logic [WORD_WIDTH-1:0] val_word;

  assign val_word = WORD_WIDTH'($unsigned(val_q));
  assign pos_ext  = PW'(pos_q);
  assign cnt_ext  = PW'(count);
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pos_cnt  = CNT_W'(pos_q);
  assign cnt_m1   = count - CNT_W'(1);
  assign km1      = k - CNT_W'(1);
  assign kp1      = k + CNT_W'(1);
  assign match    = pend && (rdata == val_word);

  // Command decode: checks, target position and starting index.
  always_comb begin
    exec_status = ST_OK;
    exec_route  = RT_DONE;
    exec_tpos   = '0;
    exec_k      = count;
    case (cmd_q)
      CMD_INSERT_AT: begin
        if (pos_ext > cnt_ext) begin
          exec_status = ST_BAD;
        end else if (full) begin
          exec_status = ST_FULL;
        end else begin
          exec_route = RT_UP;
          exec_tpos  = pos_cnt;
        end
      end
      CMD_ERASE_AT: begin
        if (pos_ext >= cnt_ext) begin
          exec_status = ST_BAD;
        end else begin
          exec_route = RT_DOWN;
          exec_tpos  = pos_cnt;
          exec_k     = pos_cnt + CNT_W'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          exec_status = ST_FULL;
        end else begin
          exec_route = RT_UP;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          exec_status = ST_FULL;
        end else begin
          exec_route = RT_UP;
          exec_tpos  = count;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          exec_status = ST_BAD;
        end else begin
          exec_route = RT_DOWN;
          exec_k     = CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          exec_status = ST_BAD;
        end else begin
          exec_route = RT_DOWN;
          exec_tpos  = cnt_m1;
        end
      end
      CMD_FIND: begin
        exec_route = RT_SEARCH;
        exec_k     = '0;
      end
      default: begin
        exec_route = RT_DONE;
      end
    endcase
  end

  // One walk step per cycle: a pending shifted word is written back while
  // the next source entry is read.
  always_comb begin
    we        = 1'b0;
    waddr     = waddr_q;
    wdata     = rdata;
    raddr     = k[IDX_W-1:0];
    rd_issue  = 1'b0;
    step_done = 1'b0;
    if (ctl.shift_up) begin
      we = pend;
      if (k > tpos) begin
        raddr    = km1[IDX_W-1:0];
        rd_issue = 1'b1;
      end else if (!pend) begin
        we        = 1'b1;
        waddr     = tpos[IDX_W-1:0];
        wdata     = val_word;
        step_done = 1'b1;
      end
    end else if (ctl.shift_down) begin
      we = pend;
      if (k < count) begin
        rd_issue = 1'b1;
      end else if (!pend) begin
        step_done = 1'b1;
      end
    end else if (ctl.search) begin
      if (match) begin
        step_done = 1'b1;
      end else if (k < count) begin
        rd_issue = 1'b1;
      end else if (!pend) begin
        step_done = 1'b1;
      end
    end
  end

  // List memory with registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Command capture, payload only.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= command;
      pos_q <= position;
      val_q <= value;
    end
  end

  // Walk index, target and pending write address.
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      k        <= exec_k;
      tpos     <= exec_tpos;
      status_q <= exec_status;
    end else if (rd_issue) begin
      if (ctl.shift_up) begin
        k       <= km1;
        waddr_q <= k[IDX_W-1:0];
      end else begin
        k       <= kp1;
        waddr_q <= km1[IDX_W-1:0];
      end
    end
  end

  // Control state: count, pending read and search hit.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else begin
      pend <= rd_issue;
      if (ctl.exec) begin
        found <= 1'b0;
        if (cmd_q == CMD_CLEAR) count <= '0;
      end else if (step_done) begin
        if (ctl.shift_up) begin
          count <= count + CNT_W'(1);
        end else if (ctl.shift_down) begin
          count <= cnt_m1;
        end else if (match) begin
          found <= 1'b1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status      <= status_q;
      entry_count <= CNT_FW'(count);
      if (cmd_q == CMD_FIND) begin
        find_result <= found ? val_q : '1;
      end else begin
        find_result <= '0;
      end
    end
  end

  assign sts.route     = exec_route;
  assign sts.step_done = step_done;
  assign sts.out_free  = !m_tvalid || m_tready;

endmodule

>>> src/sequential_list_engine_core.sv
// ----------------------------------------------------------------------------
// Sequential list engine
// Fixed-capacity ordered list of signed words with insert, erase, push,
// pop, find and clear commands; one result per command.
// ----------------------------------------------------------------------------
// One command is taken at a time. After the transfer in, a command is
// decoded, then walks the list memory one entry per cycle through its
// single registered read port: insert and push move the entries from the
// target position on up by one, erase and pop move the later entries down
// by one, find reads from the front until a hit or the end of the list,
// and clear and rejected commands need no walk. The result is then moved
// into the output register, and the next command is taken after that.
// The output register holds a finished result while the next command
// runs; a result that is still not taken when the next one is ready
// stalls the engine, and with it the input.
module sequential_list_engine_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // command [2:0], position [7:3], value [39:8]
  input  logic [slec_pkg::IN_DW-1:0]    s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status [1:0], find_result [33:2], entry_count [38:34], zero [39]
  output logic [slec_pkg::OUT_DW-1:0]   m_tdata
);
  import slec_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  logic [STAT_FW-1:0]        status;
  logic signed [VAL_FW-1:0]  find_result;
  logic [CNT_FW-1:0]         entry_count;

  slec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  slec_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .command     (s_tdata[2:0]),
    .position    (s_tdata[7:3]),
    .value       (s_tdata[39:8]),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .status      (status),
    .find_result (find_result),
    .entry_count (entry_count)
  );

  // Pack the result fields.
  assign m_tdata = {1'b0, entry_count, find_result, status};

  // Only one command is in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> !s_tready)
    else $error("input taken while a command is in flight");

  // A full status only happens with a full list.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == ST_FULL) |-> (entry_count == CNT_FW'(DEPTH)))
    else $error("full status with a list that is not full");

  // A result never reports more entries than the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (entry_count <= CNT_FW'(DEPTH)))
    else $error("entry count above capacity");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Sequential list engine testbench
// Drives list commands over the input stream and checks every reply on the
// output stream against a shadow copy of the list kept in the testbench.
// A short table of directed commands walks the empty, full and out-of-range
// cases first. Random command sequences follow; they fill and drain the list
// in turns. Both stream sides insert random gaps, and once the reply side
// holds off long enough for the engine to stall its input.
// ----------------------------------------------------------------------------
module tb_top;
  import slec_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int IDLE_LIMIT   = 3000;
  localparam int LONG_HOLD    = 250;
  localparam int DIR_ROWS     = 21;

  // The fields of one reply that the engine packs into m_tdata.
  typedef struct packed {
    logic [STAT_FW-1:0] status;
    logic [VAL_FW-1:0]  find_result;
    logic [CNT_FW-1:0]  entry_count;
  } reply_t;

  // One row of the directed table. Rows with typed set carry their reply.
  typedef struct packed {
    logic [CMD_FW-1:0]  cmd;
    logic [POS_FW-1:0]  pos;
    logic [VAL_FW-1:0]  val;
    logic [4:0]         reps;
    logic               typed;
    logic [STAT_FW-1:0] status;
    logic [VAL_FW-1:0]  find_result;
    logic [CNT_FW-1:0]  entry_count;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_DW-1:0]  s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_DW-1:0] m_tdata;

  // Shadow of the list contents and of the entry count.
  logic [VAL_FW-1:0] shadow_words [DEPTH];
  int                shadow_len;

  reply_t pending_replies [$];

  int  mismatches;
  int  commands_sent;
  int  replies_checked;
  int  full_rejects;
  int  bad_rejects;
  int  find_hits;
  int  peak_fill;
  bit  steady;
  bit  long_hold_done;
  int  idle_cycles;

  // Directed commands, starting from the empty list after reset.
  dir_row_t dir_table [DIR_ROWS] = '{
    // Removals and a far insert on the empty list are all rejected.
    '{CMD_POP_FRONT,  5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_BAD, 32'h0, 5'd0},
    '{CMD_POP_BACK,   5'd31, 32'h0000_0000, 5'd1,  1'b1, ST_BAD, 32'h0, 5'd0},
    '{CMD_ERASE_AT,   5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_BAD, 32'h0, 5'd0},
    '{CMD_INSERT_AT,  5'd1,  32'h0000_0005, 5'd1,  1'b1, ST_BAD, 32'h0, 5'd0},
    // A search in the empty list misses, and minus one comes back either way.
    '{CMD_FIND,       5'd0,  32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK, 32'hFFFF_FFFF, 5'd0},
    '{CMD_FIND,       5'd0,  32'h0000_1234, 5'd1,  1'b1, ST_OK, 32'hFFFF_FFFF, 5'd0},
    // Extreme words at both ends, then one in the middle.
    '{CMD_PUSH_BACK,  5'd31, 32'h7FFF_FFFF, 5'd1,  1'b1, ST_OK, 32'h0, 5'd1},
    '{CMD_PUSH_FRONT, 5'd0,  32'h8000_0000, 5'd1,  1'b1, ST_OK, 32'h0, 5'd2},
    '{CMD_INSERT_AT,  5'd1,  32'h0000_0000, 5'd1,  1'b0, ST_OK, 32'h0, 5'd0},
    '{CMD_FIND,       5'd0,  32'h8000_0000, 5'd1,  1'b0, ST_OK, 32'h0, 5'd0},
    '{CMD_INSERT_AT,  5'd31, 32'h0000_0009, 5'd1,  1'b1, ST_BAD, 32'h0, 5'd3},
    '{CMD_ERASE_AT,   5'd3,  32'h0000_0000, 5'd1,  1'b1, ST_BAD, 32'h0, 5'd3},
    // Fill up to capacity; the last insert lands exactly at the end.
    '{CMD_PUSH_BACK,  5'd7,  32'h0000_0100, 5'd12, 1'b0, ST_OK, 32'h0, 5'd0},
    '{CMD_INSERT_AT,  5'd15, 32'hFFFF_FFFF, 5'd1,  1'b0, ST_OK, 32'h0, 5'd0},
    // Every kind of insert into the full list, and a far insert still wins.
    '{CMD_PUSH_FRONT, 5'd0,  32'h0000_0001, 5'd1,  1'b1, ST_FULL, 32'h0, 5'd16},
    '{CMD_PUSH_BACK,  5'd0,  32'h0000_0002, 5'd1,  1'b1, ST_FULL, 32'h0, 5'd16},
    '{CMD_INSERT_AT,  5'd16, 32'h0000_0003, 5'd1,  1'b1, ST_FULL, 32'h0, 5'd16},
    '{CMD_INSERT_AT,  5'd17, 32'h0000_0004, 5'd1,  1'b1, ST_BAD, 32'h0, 5'd16},
    // Erase at both ends of the full list, then clear it twice.
    '{CMD_ERASE_AT,   5'd15, 32'h0000_0000, 5'd1,  1'b0, ST_OK, 32'h0, 5'd0},
    '{CMD_ERASE_AT,   5'd0,  32'h0000_0000, 5'd2,  1'b0, ST_OK, 32'h0, 5'd0},
    '{CMD_CLEAR,      5'd9,  32'h0000_0000, 5'd2,  1'b1, ST_OK, 32'h0, 5'd0}
  };

  sequential_list_engine_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock with a period of 20.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Insert into the shadow list; a far position is checked before capacity.
  function automatic logic [STAT_FW-1:0] shadow_insert(input int p, input logic [VAL_FW-1:0] v);
    int k;
    if (p > shadow_len) return ST_BAD;
    if (shadow_len >= DEPTH) return ST_FULL;
    for (k = shadow_len; k > p; k--) shadow_words[k] = shadow_words[k-1];
    shadow_words[p] = v;
    shadow_len++;
    if (shadow_len > peak_fill) peak_fill = shadow_len;
    return ST_OK;
  endfunction

  // Erase from the shadow list; later entries move down by one.
  function automatic logic [STAT_FW-1:0] shadow_erase(input int p);
    int k;
    if (p >= shadow_len) return ST_BAD;
    for (k = p + 1; k < shadow_len; k++) shadow_words[k-1] = shadow_words[k];
    shadow_len--;
    return ST_OK;
  endfunction

  // Apply one command to the shadow list and work out the reply it earns.
  function automatic reply_t list_apply(input logic [CMD_FW-1:0] cmd,
                                        input logic [POS_FW-1:0] pos,
                                        input logic [VAL_FW-1:0] val);
    reply_t r;
    int     k;
    r.status      = ST_OK;
    r.find_result = '0;
    case (cmd)
      CMD_INSERT_AT:  r.status = shadow_insert(int'(pos), val);
      CMD_ERASE_AT:   r.status = shadow_erase(int'(pos));
      CMD_PUSH_FRONT: r.status = shadow_insert(0, val);
      CMD_PUSH_BACK:  r.status = shadow_insert(shadow_len, val);
      CMD_POP_FRONT:  r.status = shadow_erase(0);
      CMD_POP_BACK:   r.status = (shadow_len == 0) ? ST_BAD : shadow_erase(shadow_len - 1);
      CMD_FIND: begin
        r.find_result = 32'hFFFF_FFFF;
        for (k = 0; k < shadow_len; k++) begin
          if (shadow_words[k] == val) begin
            r.find_result = val;
            find_hits++;
            break;
          end
        end
      end
      default:        shadow_len = 0;
    endcase
    if (r.status == ST_FULL) full_rejects++;
    if (r.status == ST_BAD) bad_rejects++;
    r.entry_count = CNT_FW'(shadow_len);
    return r;
  endfunction

  // Gap before the next transfer: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A word to store or search for: extremes, a small pool that repeats, or
  // any 32-bit word.
  function automatic logic [VAL_FW-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h7FFF_FFFF;
        3:       return 32'h8000_0000;
        default: return 32'h0000_0001;
      endcase
    end
    if (r < 50) return VAL_FW'($urandom_range(0, 15));
    return $urandom;
  endfunction

  // Offer one command and wait for its transfer; the reply owed is queued
  // at the transfer edge.
  task automatic send_cmd(input logic [CMD_FW-1:0] cmd, input logic [POS_FW-1:0] pos,
                          input logic [VAL_FW-1:0] val, input logic typed,
                          input reply_t typed_reply);
    int     gap;
    reply_t owed;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, pos, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    owed = list_apply(cmd, pos, val);
    if (typed) owed = typed_reply;
    pending_replies.push_back(owed);
    commands_sent++;
  endtask

  // Compare one reply transfer with the oldest reply owed.
  task automatic check_reply();
    reply_t want;
    if (pending_replies.size() == 0) begin
      $error("reply with none outstanding: data %h", m_tdata);
      mismatches++;
      return;
    end
    want = pending_replies.pop_front();
    replies_checked++;
    if (m_tdata[1:0] !== want.status) begin
      $error("status mismatch: expected %0d, got %0d", want.status, m_tdata[1:0]);
      mismatches++;
    end
    if (m_tdata[33:2] !== want.find_result) begin
      $error("find_result mismatch: expected %0d, got %0d",
             $signed(want.find_result), $signed(m_tdata[33:2]));
      mismatches++;
    end
    if (m_tdata[38:34] !== want.entry_count) begin
      $error("entry_count mismatch: expected %0d, got %0d", want.entry_count, m_tdata[38:34]);
      mismatches++;
    end
    if (m_tdata[39] !== 1'b0) begin
      $error("pad mismatch: expected 0, got %b", m_tdata[39]);
      mismatches++;
    end
  endtask

  // Reply side: random stalls, one long hold-off, stretches always ready.
  initial begin : reply_side
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) check_reply();
      if (!long_hold_done && commands_sent >= DIR_ROWS + 40) begin
        long_hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (steady) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        m_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Command side: reset, the directed table, then random sequences.
  initial begin : command_side
    int                i;
    int                j;
    int                trend;
    int                r;
    logic [CMD_FW-1:0] cmd;
    logic [POS_FW-1:0] pos;
    logic [VAL_FW-1:0] val;
    reply_t            typed_reply;

    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    steady          = 1'b0;
    long_hold_done  = 1'b0;
    mismatches      = 0;
    commands_sent   = 0;
    replies_checked = 0;
    full_rejects    = 0;
    bad_rejects     = 0;
    find_hits       = 0;
    peak_fill       = 0;
    idle_cycles     = 0;
    shadow_len      = 0;
    foreach (shadow_words[k]) shadow_words[k] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table; a repeated row steps its word for each repeat.
    for (i = 0; i < DIR_ROWS; i++) begin
      typed_reply.status      = dir_table[i].status;
      typed_reply.find_result = dir_table[i].find_result;
      typed_reply.entry_count = dir_table[i].entry_count;
      for (j = 0; j < dir_table[i].reps; j++)
        send_cmd(dir_table[i].cmd, dir_table[i].pos, dir_table[i].val + VAL_FW'(j),
                 dir_table[i].typed, typed_reply);
    end

    // Random sequences. Each phase leans toward growing, shrinking or
    // neither, so the list keeps reaching both full and empty.
    trend = 0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) begin
        trend  = $urandom_range(0, 2);
        steady = ($urandom_range(0, 3) == 0);
      end
      pos = POS_FW'($urandom_range(0, 31));
      val = pick_word();
      r   = $urandom_range(0, 99);
      if (r < 2) begin
        cmd = CMD_CLEAR;
      end else if (r < ((trend == 0) ? 57 : (trend == 1) ? 17 : 37)) begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_INSERT_AT;
          1:       cmd = CMD_PUSH_FRONT;
          default: cmd = CMD_PUSH_BACK;
        endcase
        if (cmd == CMD_INSERT_AT) begin
          if ($urandom_range(0, 99) < 85 || shadow_len >= 31)
            pos = POS_FW'($urandom_range(0, shadow_len));
          else
            pos = POS_FW'($urandom_range(shadow_len + 1, 31));
        end
      end else if (r < 75) begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_ERASE_AT;
          1:       cmd = CMD_POP_FRONT;
          default: cmd = CMD_POP_BACK;
        endcase
        if (cmd == CMD_ERASE_AT) begin
          if (shadow_len > 0 && $urandom_range(0, 99) < 85)
            pos = POS_FW'($urandom_range(0, shadow_len - 1));
          else
            pos = POS_FW'($urandom_range(shadow_len, 31));
        end
      end else begin
        cmd = CMD_FIND;
        if (shadow_len > 0 && $urandom_range(0, 99) < 60)
          val = shadow_words[$urandom_range(0, shadow_len - 1)];
      end
      send_cmd(cmd, pos, val, 1'b0, '0);
    end
    s_tvalid <= 1'b0;
    steady = 1'b0;

    // Drain the replies still owed, then watch a little longer for strays.
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);

    $display("Sent %0d commands and checked %0d replies; the list peaked at %0d of %0d.",
             commands_sent, replies_checked, peak_fill, DEPTH);
    $display("Saw %0d full rejections, %0d bad position or empty rejections, %0d find hits.",
             full_rejects, bad_rejects, find_hits);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/slec_pkg.sv
src/slec_ctrl.sv
src/slec_dpath.sv
src/sequential_list_engine_core.sv
tb/tb_top.sv
